/* rtl/core/tfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text framebuffer renderer package
// Shared geometry constants, character codes, payload types and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int PIXEL_COLUMNS   = 128;
  localparam int PAGE_COUNT      = 8;
  localparam int GLYPH_COUNT     = 91;

  localparam int CELL_WIDTH      = 6;
  localparam int LINE_LAST       = PIXEL_COLUMNS / CELL_WIDTH - 1;
  localparam int BEAT_BYTES      = 8;
  localparam int WORDS_PER_PAGE  = (PIXEL_COLUMNS + BEAT_BYTES - 1) / BEAT_BYTES;
  localparam int LAST_BEAT_BYTES = PIXEL_COLUMNS - BEAT_BYTES * (WORDS_PER_PAGE - 1);
  localparam int FB_WORDS        = PAGE_COUNT * WORDS_PER_PAGE;
  localparam int FB_AW           = $clog2(FB_WORDS);
  localparam int COL_W           = $clog2(PIXEL_COLUMNS);
  localparam int GLYPH_AW        = $clog2(GLYPH_COUNT);
  localparam int NUM_BITS        = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int CNT_W           = (FB_AW > 5) ? FB_AW : 5;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;

  typedef enum logic [2:0] {
    MODE_SET_CURSOR = 3'd0,
    MODE_DRAW       = 3'd1,
    MODE_PRINT_CHAR = 3'd2,
    MODE_PRINT_INT  = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_REFRESH    = 3'd5,
    MODE_LOAD_GLYPH = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    SRC_ITEM,
    SRC_CHAR,
    SRC_MINUS,
    SRC_DIGIT
  } cell_src_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [4:0]         col_pos;
    logic [3:0]         row_pos;
    logic [7:0]         char_code;
    logic signed [31:0] number;
    logic [6:0]         glyph_index;
    logic [47:0]        glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic        is_data;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      latch;
    logic      cursor_set;
    logic      glyph_wr;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      dab_step;
    logic      dig_init;
    logic      cell_load;
    cell_src_e cell_src;
    logic      cell_wr;
    logic      cursor_adv;
    logic      clr_wr;
    logic      fb_rd;
    logic      out_cmd;
    logic      out_data;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  row_ok;
    logic  cnt_cell_end;
    logic  cnt_dab_end;
    logic  cnt_clr_end;
    logic  cnt_page_end;
    logic  neg;
    logic  dig_left_zero;
    logic  out_free;
  } dp_status_t;

endpackage

/* rtl/core/text_framebuffer_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text framebuffer renderer
// Monochrome page framebuffer with a loadable 6-column font, a text cursor
// and a page refresh stream.
// ----------------------------------------------------------------------------
// One item is taken on the input channel when in_valid_i and in_ready_o are
// both high; its mode selects the operation. Items are processed one at a
// time. Draw at cell and print char make six single-byte framebuffer writes,
// and print char then advances the cursor. Print int does binary-to-decimal
// shifting, then prints a minus sign for a negative number and each digit.
// Clear writes one framebuffer word a cycle. Refresh of a row below PAGE_COUNT
// emits a command beat and then WORDS_PER_PAGE data beats, each read through
// the single framebuffer read port and then loaded into the output register.
// After reset the framebuffer is swept to zero, all FB_WORDS (128) words, with
// in_ready_o low. Results sit in an output register; while the receiver
// stalls, a refresh waits at its next beat and the register holds its beat,
// and a new item is still taken once the current one has finished.
// ----------------------------------------------------------------------------
module text_framebuffer_renderer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tfr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfr_pkg::out_item_t out_data_o
);
  import tfr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  tfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tfr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_cmd_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_data |-> !out_data_o.last && out_data_o.byte_count == 4'd3)
    else $error("command beat malformed");

  a_data_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_data |->
      out_data_o.byte_count != 4'd0 && out_data_o.byte_count <= 4'(BEAT_BYTES))
    else $error("data beat count out of range");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second item back to back");

  a_single_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.out_cmd && cmd.out_data))
    else $error("two output loads at once");

endmodule

/* rtl/core/tfr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text framebuffer renderer datapath
// Framebuffer and glyph memories, cursor, decimal conversion, counters and
// the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module tfr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfr_pkg::in_item_t   in_data_i,
  input  tfr_pkg::ctrl_cmd_t  cmd_i,
  output tfr_pkg::dp_status_t sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tfr_pkg::out_item_t  out_data_o
);
  import tfr_pkg::*;

  function automatic logic [4*BCD_DIGITS-1:0] dab_adjust(input logic [4*BCD_DIGITS-1:0] b);
    logic [4*BCD_DIGITS-1:0] r;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] digit_count(input logic [4*BCD_DIGITS-1:0] b);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  in_item_t                item_q;
  logic [NUM_BITS-1:0]     mag_q;
  logic [4*BCD_DIGITS-1:0] bcd_q;
  logic [4*BCD_DIGITS-1:0] bcd_adj;
  logic [3:0]              dig_left_q, dig_left_d;
  logic [5:0]              cur_col_q, cur_col_d;
  logic [3:0]              cur_row_q, cur_row_d;
  logic [5:0]              cell_col_q;
  logic [3:0]              cell_row_q;
  logic                    cell_ok_q;
  logic [47:0]             glyph_q;
  logic                    glyph_zero_q;
  logic [47:0]             glyph_mem [GLYPH_COUNT];
  logic [63:0]             fb_mem [FB_WORDS];
  logic [63:0]             fb_rdata_q;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q;

  logic [6:0]       col_inc;
  logic [4:0]       row_inc;
  logic [7:0]       sel_char, map_char, slot;
  logic [5:0]       sel_col;
  logic [3:0]       sel_row;
  logic [3:0]       dig_idx;
  logic [8:0]       cell_pix;
  logic [COL_W-1:0] pix_col;
  logic [FB_AW-1:0] cell_addr, rf_addr, wr_addr;
  logic [7:0]       cell_byte;
  logic [7:0]       wr_be;
  logic [63:0]      wr_data;
  logic             wr_en;

  assign col_inc = {1'b0, cur_col_q} + 7'd1;
  assign row_inc = {1'b0, cur_row_q} + 5'd1;
  assign dig_idx = dig_left_q - 4'd1;
  assign bcd_adj = dab_adjust(bcd_q);

  always_comb begin
    sel_col  = cur_col_q;
    sel_row  = cur_row_q;
    sel_char = item_q.char_code;
    case (cmd_i.cell_src)
      SRC_ITEM: begin
        sel_col = {1'b0, item_q.col_pos};
        sel_row = item_q.row_pos;
      end
      SRC_MINUS: sel_char = CHAR_MINUS;
      SRC_DIGIT: sel_char = CHAR_ZERO + {4'd0, bcd_q[{dig_idx, 2'b00} +: 4]};
      default: ;
    endcase
    map_char = (sel_char < CHAR_SPACE || sel_char > CHAR_LAST) ? CHAR_SPACE : sel_char;
    slot     = map_char - CHAR_SPACE;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    dig_left_d = dig_left_q;
    if (cmd_i.latch) begin
      dig_left_d = 4'd0;
    end else if (cmd_i.dig_init) begin
      dig_left_d = digit_count(bcd_q);
    end else if (cmd_i.cell_load && cmd_i.cell_src == SRC_DIGIT) begin
      dig_left_d = dig_idx;
    end
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cmd_i.cursor_set) begin
      cur_col_d = {1'b0, item_q.col_pos};
      cur_row_d = item_q.row_pos;
    end else if (cmd_i.cursor_adv) begin
      if (col_inc > 7'(LINE_LAST)) begin
        cur_col_d = 6'd0;
        cur_row_d = (row_inc >= 5'(PAGE_COUNT)) ? 4'd0 : row_inc[3:0];
      end else begin
        cur_col_d = col_inc[5:0];
      end
    end
    out_valid_d = out_valid_q;
    if (cmd_i.out_cmd || cmd_i.out_data) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dig_left_q  <= 4'd0;
      cur_col_q   <= 6'd0;
      cur_row_q   <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      dig_left_q  <= dig_left_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
      mag_q  <= in_data_i.number[NUM_BITS-1] ? (NUM_BITS'(0) - in_data_i.number)
                                             : in_data_i.number;
      bcd_q  <= '0;
    end else if (cmd_i.dab_step) begin
      mag_q <= {mag_q[NUM_BITS-2:0], 1'b0};
      bcd_q <= {bcd_adj[4*BCD_DIGITS-2:0], mag_q[NUM_BITS-1]};
    end
    if (cmd_i.cell_load) begin
      cell_col_q   <= sel_col;
      cell_row_q   <= sel_row;
      cell_ok_q    <= (sel_col <= 6'(LINE_LAST)) && (sel_row < 4'(PAGE_COUNT));
      glyph_q      <= glyph_mem[slot[GLYPH_AW-1:0]];
      glyph_zero_q <= (slot >= 8'(GLYPH_COUNT));
    end
    if (cmd_i.glyph_wr && item_q.glyph_index < 7'(GLYPH_COUNT)) begin
      glyph_mem[item_q.glyph_index[GLYPH_AW-1:0]] <= item_q.glyph_bits;
    end
    if (cmd_i.out_cmd) begin
      out_q.is_data    <= 1'b0;
      out_q.payload    <= {40'd0, CMD_COL_HIGH, CMD_COL_LOW, CMD_PAGE + {4'd0, item_q.row_pos}};
      out_q.byte_count <= 4'd3;
      out_q.last       <= 1'b0;
    end else if (cmd_i.out_data) begin
      out_q.is_data    <= 1'b1;
      out_q.payload    <= fb_rdata_q;
      out_q.byte_count <= sts_o.cnt_page_end ? 4'(LAST_BEAT_BYTES) : 4'(BEAT_BYTES);
      out_q.last       <= sts_o.cnt_page_end;
    end
  end

  assign cell_pix  = 9'(cell_col_q) * 9'(CELL_WIDTH) + {6'd0, cnt_q[2:0]};
  assign pix_col   = cell_pix[COL_W-1:0];
  assign cell_addr = FB_AW'(cell_row_q) * FB_AW'(WORDS_PER_PAGE) + FB_AW'(pix_col[COL_W-1:3]);
  assign rf_addr   = FB_AW'(item_q.row_pos) * FB_AW'(WORDS_PER_PAGE) + cnt_q[FB_AW-1:0];
  assign cell_byte = glyph_zero_q ? 8'd0 : glyph_q[{cnt_q[2:0], 3'b000} +: 8];

  always_comb begin
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[FB_AW-1:0];
      wr_be   = 8'hFF;
      wr_data = 64'd0;
    end else begin
      wr_en   = cmd_i.cell_wr && cell_ok_q;
      wr_addr = cell_addr;
      wr_be   = 8'd1 << pix_col[2:0];
      wr_data = {8{cell_byte}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int l = 0; l < BEAT_BYTES; l++) begin
        if (wr_be[l]) begin
          fb_mem[wr_addr][8*l +: 8] <= wr_data[8*l +: 8];
        end
      end
    end
    if (cmd_i.fb_rd) begin
      fb_rdata_q <= fb_mem[rf_addr];
    end
  end

  assign sts_o.mode          = mode_e'(item_q.mode);
  assign sts_o.row_ok        = item_q.row_pos < 4'(PAGE_COUNT);
  assign sts_o.cnt_cell_end  = cnt_q == CNT_W'(CELL_WIDTH - 1);
  assign sts_o.cnt_dab_end   = cnt_q == CNT_W'(NUM_BITS - 1);
  assign sts_o.cnt_clr_end   = cnt_q == CNT_W'(FB_WORDS - 1);
  assign sts_o.cnt_page_end  = cnt_q == CNT_W'(WORDS_PER_PAGE - 1);
  assign sts_o.neg           = item_q.number[NUM_BITS-1];
  assign sts_o.dig_left_zero = dig_left_q == 4'd0;
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/tfr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text framebuffer renderer controller
// Sequences the clearing pass, cursor setting, font loading, glyph drawing,
// decimal printing and page refresh by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module tfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfr_pkg::dp_status_t sts_i,
  output tfr_pkg::ctrl_cmd_t  cmd_o
);
  import tfr_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_DABBLE,
    ST_DIGITS,
    ST_NEXT,
    ST_CELL_WR,
    ST_ADV,
    ST_RF_CMD,
    ST_RF_RD,
    ST_RF_LD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.cell_src = SRC_ITEM;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_clr_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.cnt_clr = 1'b1;
        unique case (sts_i.mode)
          MODE_SET_CURSOR: begin
            cmd_o.cursor_set = 1'b1;
            state_d          = ST_IDLE;
          end
          MODE_DRAW: begin
            cmd_o.cell_load = 1'b1;
            cmd_o.cell_src  = SRC_ITEM;
            state_d         = ST_CELL_WR;
          end
          MODE_PRINT_CHAR: begin
            cmd_o.cell_load = 1'b1;
            cmd_o.cell_src  = SRC_CHAR;
            state_d         = ST_CELL_WR;
          end
          MODE_PRINT_INT: state_d = ST_DABBLE;
          MODE_CLEAR:     state_d = ST_CLEAR;
          MODE_REFRESH:   state_d = sts_i.row_ok ? ST_RF_CMD : ST_IDLE;
          MODE_LOAD_GLYPH: begin
            cmd_o.glyph_wr = 1'b1;
            state_d        = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DABBLE: begin
        cmd_o.dab_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.cnt_dab_end) begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        cmd_o.dig_init = 1'b1;
        if (sts_i.neg) begin
          cmd_o.cell_load = 1'b1;
          cmd_o.cell_src  = SRC_MINUS;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = ST_CELL_WR;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!sts_i.dig_left_zero) begin
          cmd_o.cell_load = 1'b1;
          cmd_o.cell_src  = SRC_DIGIT;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = ST_CELL_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CELL_WR: begin
        cmd_o.cell_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_cell_end) begin
          state_d = (sts_i.mode == MODE_DRAW) ? ST_IDLE : ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.cursor_adv = 1'b1;
        state_d = (sts_i.mode == MODE_PRINT_INT) ? ST_NEXT : ST_IDLE;
      end
      ST_RF_CMD: begin
        if (sts_i.out_free) begin
          cmd_o.out_cmd = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_RF_RD;
        end
      end
      ST_RF_RD: begin
        cmd_o.fb_rd = 1'b1;
        state_d     = ST_RF_LD;
      end
      ST_RF_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_data = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          state_d        = sts_i.cnt_page_end ? ST_IDLE : ST_RF_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

/* tb/tb_text_framebuffer_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text framebuffer renderer testbench
// Drives random and directed text operations into the renderer, predicts the
// framebuffer, font and cursor in a scoreboard, and checks every refresh beat.
// ----------------------------------------------------------------------------
module tb_text_framebuffer_renderer;
  import tfr_pkg::*;

  class frame_scoreboard;
    logic [7:0]  frame [PAGE_COUNT*PIXEL_COLUMNS];
    logic [47:0] glyphs [GLYPH_COUNT];
    int unsigned cur_col;
    int unsigned cur_row;
    out_item_t   pending_beats[$];

    function void clear_frame();
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    function void put_cell(int unsigned x, int unsigned y, logic [7:0] c);
      int unsigned base;
      int unsigned slot;
      logic [47:0] g;
      if (x * CELL_WIDTH + CELL_WIDTH > PIXEL_COLUMNS) return;
      if (y >= PAGE_COUNT) return;
      if (c < CHAR_SPACE || c > CHAR_LAST) c = CHAR_SPACE;
      slot = c - CHAR_SPACE;
      g = (slot < GLYPH_COUNT) ? glyphs[slot] : 48'h0;
      base = y * PIXEL_COLUMNS + x * CELL_WIDTH;
      for (int i = 0; i < CELL_WIDTH; i++) frame[base+i] = g[8*i +: 8];
    endfunction

    function void print_char(logic [7:0] c);
      put_cell(cur_col, cur_row, c);
      cur_col++;
      if (cur_col > LINE_LAST) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= PAGE_COUNT) cur_row = 0;
      end
    endfunction

    function void note_item(in_item_t it);
      logic [31:0] mag;
      logic [7:0]  digs[$];
      out_item_t   b;
      int unsigned x;
      case (it.mode)
        MODE_SET_CURSOR: begin
          cur_col = it.col_pos;
          cur_row = it.row_pos;
        end
        MODE_DRAW: put_cell(it.col_pos, it.row_pos, it.char_code);
        MODE_PRINT_CHAR: print_char(it.char_code);
        MODE_PRINT_INT: begin
          mag = it.number[31] ? 32'd0 - it.number : it.number;
          do begin
            digs.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
          end while (mag != 0);
          if (it.number[31]) print_char(CHAR_MINUS);
          foreach (digs[i]) print_char(digs[i]);
        end
        MODE_CLEAR: clear_frame();
        MODE_REFRESH: begin
          if (it.row_pos < PAGE_COUNT) begin
            b = '0;
            b.payload = {40'h0, CMD_COL_HIGH, CMD_COL_LOW, CMD_PAGE + 8'(it.row_pos)};
            b.byte_count = 4'd3;
            pending_beats.push_back(b);
            x = 0;
            while (x < PIXEL_COLUMNS) begin
              b = '0;
              b.is_data = 1'b1;
              while (b.byte_count < 8 && x < PIXEL_COLUMNS) begin
                b.payload[8*b.byte_count +: 8] = frame[it.row_pos*PIXEL_COLUMNS + x];
                b.byte_count++;
                x++;
              end
              b.last = (x >= PIXEL_COLUMNS);
              pending_beats.push_back(b);
            end
          end
        end
        MODE_LOAD_GLYPH: if (it.glyph_index < GLYPH_COUNT) glyphs[it.glyph_index] = it.glyph_bits;
        default: ;
      endcase
    endfunction

    task check_beat(out_item_t got);
      out_item_t exp_b;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", 64'd0, 64'd1);
        return;
      end
      exp_b = pending_beats.pop_front();
      if (got.is_data !== exp_b.is_data)
        report_mismatch("is_data", 64'(got.is_data), 64'(exp_b.is_data));
      if (got.payload !== exp_b.payload) report_mismatch("payload", got.payload, exp_b.payload);
      if (got.byte_count !== exp_b.byte_count)
        report_mismatch("byte_count", 64'(got.byte_count), 64'(exp_b.byte_count));
      if (got.last !== exp_b.last) report_mismatch("last", 64'(got.last), 64'(exp_b.last));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  frame_scoreboard sb;
  int  mismatches = 0;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  quiet_cycles;
  int  items_sent;
  int  beats_seen;
  int  refreshes;
  bit  glyph_loaded [GLYPH_COUNT];

  text_framebuffer_renderer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    sb = new();
    sb.clear_frame();
    foreach (sb.glyphs[i]) sb.glyphs[i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_beat(out_data);
      beats_seen++;
    end
    if (rst_n && in_valid && in_ready) sb.note_item(in_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Timeout: nothing accepted for too long");
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_beat(in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (it.mode == MODE_REFRESH && it.row_pos < PAGE_COUNT) refreshes++;
  endtask

  function automatic logic [7:0] loaded_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c >= CHAR_SPACE && c <= CHAR_LAST &&
                                          !glyph_loaded[c - CHAR_SPACE]);
    if (!glyph_loaded[0] && (c < CHAR_SPACE || c > CHAR_LAST)) c = CHAR_SPACE + 8'd33;
    return c;
  endfunction

  function automatic in_item_t rand_item(int unsigned mode);
    in_item_t it;
    it.mode        = 3'(mode);
    it.col_pos     = 5'($urandom);
    it.row_pos     = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(7));
    it.char_code   = loaded_char();
    it.number      = (mode == MODE_PRINT_INT && $urandom_range(1)) ?
                     32'($urandom_range(999)) : $urandom;
    it.glyph_index = 7'($urandom);
    it.glyph_bits  = 48'({$urandom, $urandom});
    return it;
  endfunction

  task automatic load_glyph(int idx, logic [47:0] bits);
    in_item_t it;
    it = rand_item(MODE_LOAD_GLYPH);
    it.glyph_index = 7'(idx);
    it.glyph_bits  = bits;
    if (idx < GLYPH_COUNT) glyph_loaded[idx] = 1'b1;
    send_beat(it);
  endtask

  task automatic send_op(int unsigned mode, int col, int row, int code, logic [31:0] num);
    in_item_t it;
    it = rand_item(mode);
    it.col_pos   = 5'(col);
    it.row_pos   = 4'(row);
    it.char_code = 8'(code);
    it.number    = num;
    send_beat(it);
  endtask

  task automatic wait_drained();
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int unsigned m;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(99);
      if (m < 8)       m = MODE_SET_CURSOR;
      else if (m < 22) m = MODE_DRAW;
      else if (m < 42) m = MODE_PRINT_CHAR;
      else if (m < 56) m = MODE_PRINT_INT;
      else if (m < 59) m = MODE_CLEAR;
      else if (m < 80) m = MODE_REFRESH;
      else if (m < 97) m = MODE_LOAD_GLYPH;
      else             m = 7;
      if (m == MODE_LOAD_GLYPH && $urandom_range(1))
        load_glyph($urandom_range(127), 48'({$urandom, $urandom}));
      else send_beat(rand_item(m));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 73;
    quiet_cycles = 0;
    items_sent = 0;
    beats_seen = 0;
    refreshes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load the whole font so every printable code has a known glyph.
    for (int g = 0; g < GLYPH_COUNT; g++) load_glyph(g, 48'({$urandom, $urandom}));
    load_glyph(0, 48'hFFFF_FFFF_FFFF);
    load_glyph(90, 48'h0);
    load_glyph(127, 48'hFFFF_FFFF_FFFF);
    send_op(MODE_DRAW, 0, 0, 8'h7A, 0);
    send_op(MODE_DRAW, 20, 7, 8'h41, 0);
    send_op(MODE_DRAW, 21, 0, 8'h41, 0);
    send_op(MODE_DRAW, 31, 15, 8'hFF, 0);
    send_op(MODE_DRAW, 1, 8, 8'h41, 0);
    send_op(MODE_DRAW, 2, 1, 8'h00, 0);
    send_op(MODE_DRAW, 3, 1, 8'h7B, 0);
    send_op(MODE_SET_CURSOR, 19, 7, 0, 0);
    send_op(MODE_PRINT_INT, 0, 0, 0, 32'h8000_0000);
    send_op(MODE_PRINT_INT, 0, 0, 0, 32'h7FFF_FFFF);
    send_op(MODE_PRINT_INT, 0, 0, 0, 32'h0);
    send_op(MODE_SET_CURSOR, 31, 15, 0, 0);
    send_op(MODE_PRINT_CHAR, 0, 0, 8'h00, 0);
    send_op(MODE_PRINT_CHAR, 0, 0, 8'h5A, 0);
    send_op(MODE_REFRESH, 0, 0, 0, 0);
    send_op(MODE_REFRESH, 0, 7, 0, 0);
    send_op(MODE_REFRESH, 0, 8, 0, 0);
    send_op(7, 0, 0, 0, 0);
    send_op(MODE_CLEAR, 0, 0, 0, 0);
    send_op(MODE_REFRESH, 0, 0, 0, 0);

    random_phase(30);
    send_idle_pct = 73;
    recv_idle_pct = 17;
    random_phase(30);

    // Long receiver stall while the sender keeps offering refreshes.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_idle_pct = 0;
        for (int i = 0; i < 4; i++) send_op(MODE_REFRESH, 0, i, 0, 0);
      end
    join

    recv_idle_pct = 0;
    random_phase(30);
    in_valid <= 1'b0;
    wait_drained();

    $display("Covered %0d items including %0d page refreshes and %0d output beats,",
             items_sent, refreshes, beats_seen);
    $display("with font loads, cell draws, wrapped prints, integers and clears.");
    if (mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* text_framebuffer_renderer.f */
rtl/core/tfr_pkg.sv
rtl/core/tfr_datapath.sv
rtl/core/tfr_ctrl.sv
rtl/core/text_framebuffer_renderer.sv
tb/tb_text_framebuffer_renderer.sv
